// ===== rtl/pulse_charge_integrator_core_assert.svh =====
// Assertion macros used by the pulse charge integrator accumulator.
`ifndef PULSE_CHARGE_INTEGRATOR_CORE_ASSERT_SVH
`define PULSE_CHARGE_INTEGRATOR_CORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define PCI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define PCI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pci_pkg.sv =====
// Package with constants and types of the pulse charge integrator.
package pci_pkg;

  localparam int unsigned SAMPLE_BITS = 14;
  localparam int unsigned GROUP_SIZE  = 4;
  localparam int unsigned MAX_SAMPLES = 2048;
  localparam int unsigned MAX_BINS    = MAX_SAMPLES / GROUP_SIZE;

  localparam int unsigned FILL_W   = $clog2(GROUP_SIZE);
  localparam int unsigned BIN_W    = 10;
  localparam int unsigned GROUP_W  = 16;
  localparam int unsigned CHARGE_W = 25;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd4;

  // Reset values of the configuration registers
  localparam logic [SAMPLE_BITS-1:0] RST_BASELINE    = 14'd188;
  localparam logic [BIN_W-1:0]       RST_TOTAL_START = 10'd145;
  localparam logic [BIN_W-1:0]       RST_WINDOW_END  = 10'd500;
  localparam logic [BIN_W-1:0]       RST_TAIL_START  = 10'd201;
  localparam logic [SAMPLE_BITS-1:0] RST_THRESHOLD   = 14'd10;

  localparam logic [GROUP_W-1:0]  GROUP_MAX  = '1;
  localparam logic [CHARGE_W-1:0] CHARGE_MAX = '1;

  // Window and threshold settings used by the accumulator
  typedef struct packed {
    logic [BIN_W-1:0]       total_start;
    logic [BIN_W-1:0]       window_end;
    logic [BIN_W-1:0]       tail_start;
    logic [SAMPLE_BITS-1:0] threshold;
  } win_cfg_t;

  // One inverted sample held in the input register
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] inv;
    logic                   last;
  } stage_t;

endpackage

// ===== rtl/pci_if.sv =====
// Stream interfaces for input samples and result items.
interface pci_in_if
  import pci_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_sample;
  logic                   last_sample;

  modport source (output valid, output raw_sample, output last_sample, input ready);
  modport sink   (input valid, input raw_sample, input last_sample, output ready);
endinterface

interface pci_out_if
  import pci_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [GROUP_W-1:0]     group_sum;
  logic [CHARGE_W-1:0]    total_charge;
  logic [CHARGE_W-1:0]    tail_charge;
  logic [SAMPLE_BITS-1:0] peak_height;
  logic                   above_threshold;
  logic                   waveform_end;

  modport source (output valid, output group_sum, output total_charge, output tail_charge,
                  output peak_height, output above_threshold, output waveform_end,
                  input ready);
  modport sink   (input valid, input group_sum, input total_charge, input tail_charge,
                  input peak_height, input above_threshold, input waveform_end,
                  output ready);
endinterface

// ===== rtl/pci_front.sv =====
// Configuration registers, sample inversion and input register.
module pci_front
  import pci_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pci_in_if.sink                in_i,
  input  logic                  adv_i,
  output logic                  stage_valid_o,
  output stage_t                stage_o,
  output win_cfg_t              win_cfg_o
);

  logic [SAMPLE_BITS-1:0] baseline_q;
  win_cfg_t               win_q;
  logic                   valid_q, valid_d;
  stage_t                 stage_q, stage_d;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q          <= RST_BASELINE;
      win_q.total_start   <= RST_TOTAL_START;
      win_q.window_end    <= RST_WINDOW_END;
      win_q.tail_start    <= RST_TAIL_START;
      win_q.threshold     <= RST_THRESHOLD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASELINE:    baseline_q        <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_TOTAL_START: win_q.total_start <= cfg_data_i[BIN_W-1:0];
        REG_WINDOW_END:  win_q.window_end  <= cfg_data_i[BIN_W-1:0];
        REG_TAIL_START:  win_q.tail_start  <= cfg_data_i[BIN_W-1:0];
        REG_THRESHOLD:   win_q.threshold   <= cfg_data_i[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Accept when the stage is empty or moves on this cycle
  assign in_i.ready = !valid_q || adv_i;

  // Invert the sample; a negative difference becomes one
  always_comb begin
    stage_d.last = in_i.last_sample;
    if (baseline_q >= in_i.raw_sample) begin
      stage_d.inv = baseline_q - in_i.raw_sample;
    end else begin
      stage_d.inv = SAMPLE_BITS'(1);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (in_i.valid && in_i.ready) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until the next transfer
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      stage_q <= stage_d;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_o       = stage_q;
  assign win_cfg_o     = win_q;

endmodule

// ===== rtl/pci_accum.sv =====
// Group, charge and peak accumulation with the result register.
`include "pulse_charge_integrator_core_assert.svh"

module pci_accum
  import pci_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     stage_valid_i,
  input  stage_t   stage_i,
  input  win_cfg_t win_cfg_i,
  output logic     adv_o,
  pci_out_if.source out_o
);

  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [GROUP_W-1:0]     group_q, group_d;
  logic [BIN_W-1:0]       bin_q, bin_d;
  logic [CHARGE_W-1:0]    tot_q, tot_d;
  logic [CHARGE_W-1:0]    tail_q, tail_d;
  logic [SAMPLE_BITS-1:0] peak_q, peak_d;

  logic                   active, close, produce, adv;
  logic [GROUP_W:0]       group_sum_w;
  logic [GROUP_W-1:0]     group_next;
  logic [SAMPLE_BITS-1:0] peak_next;
  logic [CHARGE_W-1:0]    tot_next, tail_next;
  logic [CHARGE_W:0]      tot_sum_w, tail_sum_w;
  logic                   in_total, in_tail;

  logic                   out_valid_q, out_valid_d;
  logic [GROUP_W-1:0]     out_group_q;
  logic [CHARGE_W-1:0]    out_tot_q, out_tail_q;
  logic [SAMPLE_BITS-1:0] out_peak_q;
  logic                   out_above_q, out_end_q;

  // Move the stage forward when the result register is free
  assign adv   = stage_valid_i && (!out_valid_q || out_o.ready);
  assign adv_o = adv;

  // Per-sample datapath
  always_comb begin
    active      = bin_q < BIN_W'(MAX_BINS);
    group_sum_w = {1'b0, group_q} + (GROUP_W+1)'(stage_i.inv);
    group_next  = group_sum_w[GROUP_W] ? GROUP_MAX : group_sum_w[GROUP_W-1:0];
    peak_next   = (active && stage_i.inv > peak_q) ? stage_i.inv : peak_q;
    close       = active && ((fill_q == FILL_W'(GROUP_SIZE - 1)) || stage_i.last);
    produce     = close || stage_i.last;
    in_total    = bin_q >= win_cfg_i.total_start && bin_q < win_cfg_i.window_end;
    in_tail     = bin_q >= win_cfg_i.tail_start && bin_q < win_cfg_i.window_end;
    tot_sum_w   = {1'b0, tot_q} + (CHARGE_W+1)'(group_next);
    tail_sum_w  = {1'b0, tail_q} + (CHARGE_W+1)'(group_next);
    tot_next    = tot_q;
    tail_next   = tail_q;
    if (close && in_total) begin
      tot_next = tot_sum_w[CHARGE_W] ? CHARGE_MAX : tot_sum_w[CHARGE_W-1:0];
    end
    if (close && in_tail) begin
      tail_next = tail_sum_w[CHARGE_W] ? CHARGE_MAX : tail_sum_w[CHARGE_W-1:0];
    end
  end

  // Advance the waveform state; clear it after the last sample
  always_comb begin
    fill_d  = fill_q;
    group_d = group_q;
    bin_d   = bin_q;
    tot_d   = tot_q;
    tail_d  = tail_q;
    peak_d  = peak_q;
    if (adv) begin
      if (stage_i.last) begin
        fill_d  = '0;
        group_d = '0;
        bin_d   = '0;
        tot_d   = '0;
        tail_d  = '0;
        peak_d  = '0;
      end else if (active) begin
        peak_d = peak_next;
        tot_d  = tot_next;
        tail_d = tail_next;
        if (close) begin
          fill_d  = '0;
          group_d = '0;
          bin_d   = bin_q + BIN_W'(1);
        end else begin
          fill_d  = fill_q + FILL_W'(1);
          group_d = group_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      group_q <= '0;
      bin_q   <= '0;
      tot_q   <= '0;
      tail_q  <= '0;
      peak_q  <= '0;
    end else begin
      fill_q  <= fill_d;
      group_q <= group_d;
      bin_q   <= bin_d;
      tot_q   <= tot_d;
      tail_q  <= tail_d;
      peak_q  <= peak_d;
    end
  end

  // Result register valid: load on advance, drop after transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = produce;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_group_q <= close ? group_next : '0;
      out_tot_q   <= stage_i.last ? tot_next : '0;
      out_tail_q  <= stage_i.last ? tail_next : '0;
      out_peak_q  <= stage_i.last ? peak_next : '0;
      out_above_q <= stage_i.last && (peak_next > win_cfg_i.threshold);
      out_end_q   <= stage_i.last;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.group_sum       = out_group_q;
  assign out_o.total_charge    = out_tot_q;
  assign out_o.tail_charge     = out_tail_q;
  assign out_o.peak_height     = out_peak_q;
  assign out_o.above_threshold = out_above_q;
  assign out_o.waveform_end    = out_end_q;

  `PCI_ASSERT(a_bin_range, bin_q <= BIN_W'(MAX_BINS), "bin index past the bin limit")
  `PCI_ASSERT_NEXT(a_clear_after_end, adv && stage_i.last,
                   bin_q == '0 && peak_q == '0 && tot_q == '0 && tail_q == '0,
                   "waveform state not cleared after the last sample")
  `PCI_ASSERT_NEXT(a_bin_step, adv && close && !stage_i.last,
                   bin_q == $past(bin_q) + BIN_W'(1), "closed group did not advance the bin")
  `PCI_ASSERT(a_totals_only_at_end,
              !out_valid_q || out_end_q || (out_tot_q == '0 && out_tail_q == '0
              && out_peak_q == '0), "totals present on a result that is not the end")

endmodule

// ===== rtl/pulse_charge_integrator_core.sv =====
// Top level of the pulse charge integrator.
// Usage:
//   in_i carries one digitizer sample per transfer (raw_sample, last_sample).
//   out_o carries result items: one when a group of four samples closes,
//   holding the group sum, and one on the last sample of a waveform, which
//   also holds total charge, tail charge, peak height and the threshold flag.
//   The cfg_* port writes the five settings; write only while idle.
// Timing:
//   A sample enters the input register at its transfer; when the result
//   register is free it is accumulated and any result it causes is loaded
//   into the result register. One sample per cycle is sustained while
//   out_o.ready stays high; the accumulator update (group add, window compare,
//   charge add) is the feedback loop through the waveform state.
// Reset:
//   rst_ni clears all waveform state and restores the default settings;
//   no result is pending after reset.
// Stall:
//   While a result waits in the result register the input register still
//   takes one more sample; further samples wait until out_o.ready rises.
module pulse_charge_integrator_core
  import pci_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pci_in_if.sink                in_i,
  pci_out_if.source             out_o
);

  logic     stage_valid;
  stage_t   stage;
  win_cfg_t win_cfg;
  logic     adv;

  pci_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_i          (in_i),
    .adv_i         (adv),
    .stage_valid_o (stage_valid),
    .stage_o       (stage),
    .win_cfg_o     (win_cfg)
  );

  pci_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_valid_i (stage_valid),
    .stage_i       (stage),
    .win_cfg_i     (win_cfg),
    .adv_o         (adv),
    .out_o         (out_o)
  );

endmodule

// ===== tb/sv/pulse_charge_integrator_core_test.sv =====
// Self-checking testbench of the pulse charge integrator core.
module pulse_charge_integrator_core_test;
  import pci_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned BIN_LIMIT   = 512;
  localparam int unsigned SETTLE_CYC  = 8;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned LONG_WAVE   = MAX_SAMPLES + 3;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raw_sample;
    logic                   last_sample;
  } sample_item_t;

  typedef struct packed {
    logic [GROUP_W-1:0]     group_sum;
    logic [CHARGE_W-1:0]    total_charge;
    logic [CHARGE_W-1:0]    tail_charge;
    logic [SAMPLE_BITS-1:0] peak_height;
    logic                   above_threshold;
    logic                   waveform_end;
  } pulse_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  pci_in_if  in_if ();
  pci_out_if out_if ();

  pulse_charge_integrator_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Settings as the block holds them
  logic [SAMPLE_BITS-1:0] set_baseline    = RST_BASELINE;
  logic [BIN_W-1:0]       set_total_start = RST_TOTAL_START;
  logic [BIN_W-1:0]       set_window_end  = RST_WINDOW_END;
  logic [BIN_W-1:0]       set_tail_start  = RST_TAIL_START;
  logic [SAMPLE_BITS-1:0] set_threshold   = RST_THRESHOLD;

  // Waveform state of the charge predictor
  int unsigned            fill_count = 0;
  logic [GROUP_W-1:0]     group_acc  = '0;
  int unsigned            bin_count  = 0;
  logic [CHARGE_W-1:0]    total_acc  = '0;
  logic [CHARGE_W-1:0]    tail_acc   = '0;
  logic [SAMPLE_BITS-1:0] peak_level = '0;

  sample_item_t  pending_samples[$];
  pulse_result_t expected_results[$];
  pulse_result_t oldest_expect;

  bit          idle_enable = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned samples_queued = 0;
  int unsigned samples_sent = 0;
  int unsigned waveforms_queued = 0;
  int unsigned phase_count = 0;
  int unsigned results_checked = 0;
  int unsigned ends_checked = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Draw an idle length: mostly none or short, a few long
  function automatic int unsigned draw_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Draw a raw sample around the baseline: any value, flat, above, shallow noise or deep pulse
  function automatic logic [SAMPLE_BITS-1:0] draw_raw(input logic [SAMPLE_BITS-1:0] base);
    int unsigned pick;
    int unsigned b;
    pick = $urandom_range(0, 15);
    b = base;
    if (pick == 0) return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    if (pick == 1) return base;
    if (pick == 2 && b < SAMPLE_MAX) return SAMPLE_BITS'($urandom_range(b + 1, SAMPLE_MAX));
    if (pick < 8) return SAMPLE_BITS'(b - $urandom_range(0, (b < 40) ? b : 40));
    return SAMPLE_BITS'(b - $urandom_range(0, b));
  endfunction

  // Invert, accumulate and close groups; queue the result a sample causes
  function automatic void integrate_sample(input logic [SAMPLE_BITS-1:0] raw,
                                           input logic last);
    logic [SAMPLE_BITS-1:0] inv;
    logic [GROUP_W:0]       group_next;
    logic [CHARGE_W:0]      charge_next;
    pulse_result_t          res;
    bit                     closed;
    closed = 1'b0;
    res = '0;
    if (bin_count < MAX_BINS) begin
      inv = (set_baseline >= raw) ? set_baseline - raw : SAMPLE_BITS'(1);
      if (inv > peak_level) peak_level = inv;
      group_next = group_acc + inv;
      group_acc = (group_next > GROUP_MAX) ? GROUP_MAX : group_next[GROUP_W-1:0];
      fill_count++;
      if (fill_count >= GROUP_SIZE || last) begin
        res.group_sum = group_acc;
        if (bin_count >= set_total_start && bin_count < set_window_end) begin
          charge_next = total_acc + res.group_sum;
          total_acc = (charge_next > CHARGE_MAX) ? CHARGE_MAX : charge_next[CHARGE_W-1:0];
        end
        if (bin_count >= set_tail_start && bin_count < set_window_end) begin
          charge_next = tail_acc + res.group_sum;
          tail_acc = (charge_next > CHARGE_MAX) ? CHARGE_MAX : charge_next[CHARGE_W-1:0];
        end
        bin_count++;
        fill_count = 0;
        group_acc = '0;
        closed = 1'b1;
      end
    end
    if (!closed && !last) return;
    if (last) begin
      res.total_charge    = total_acc;
      res.tail_charge     = tail_acc;
      res.peak_height     = peak_level;
      res.above_threshold = (peak_level > set_threshold);
      res.waveform_end    = 1'b1;
      fill_count = 0;
      group_acc  = '0;
      bin_count  = 0;
      total_acc  = '0;
      tail_acc   = '0;
      peak_level = '0;
    end
    expected_results = {expected_results, res};
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic queue_sample(input int unsigned raw, input bit last);
    sample_item_t item;
    item.raw_sample  = SAMPLE_BITS'(raw);
    item.last_sample = last;
    pending_samples = {pending_samples, item};
    samples_queued++;
    if (last) waveforms_queued++;
  endtask

  task automatic queue_waveform(input int unsigned len, input logic [SAMPLE_BITS-1:0] base);
    for (int unsigned k = 0; k < len; k++) queue_sample(draw_raw(base), k == len - 1);
  endtask

  // Write one setting while the block is idle and mirror it
  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(data);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    case (idx)
      REG_BASELINE:    set_baseline    = SAMPLE_BITS'(data);
      REG_TOTAL_START: set_total_start = BIN_W'(data);
      REG_WINDOW_END:  set_window_end  = BIN_W'(data);
      REG_TAIL_START:  set_tail_start  = BIN_W'(data);
      REG_THRESHOLD:   set_threshold   = SAMPLE_BITS'(data);
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int unsigned base, input int unsigned total_start,
                                input int unsigned win_end, input int unsigned tail_start,
                                input int unsigned threshold);
    write_setting(REG_BASELINE, base);
    write_setting(REG_TOTAL_START, total_start);
    write_setting(REG_WINDOW_END, win_end);
    write_setting(REG_TAIL_START, tail_start);
    write_setting(REG_THRESHOLD, threshold);
    phase_count++;
  endtask

  // Hold until every sample is transferred and every result checked, then settle
  task automatic wait_drained();
    while (samples_sent != samples_queued || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Guard against a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[%0t] timeout after %0d cycles", $time, cycle_count);
    $display("TB_ERROR");
    $finish;
  end

  // Sample driver: transfer queued samples with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        integrate_sample(in_if.raw_sample, in_if.last_sample);
        samples_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_if.valid       <= 1'b1;
          in_if.raw_sample  <= pending_samples[0].raw_sample;
          in_if.last_sample <= pending_samples[0].last_sample;
          pending_samples.pop_front();
          gap_left = idle_enable ? draw_gap() : 0;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("[%0t] unexpected result: expected none, actual group_sum %0d end %0d",
                   $time, out_if.group_sum, out_if.waveform_end);
          error_count++;
        end else begin
          oldest_expect = expected_results.pop_front();
          compare_field("group_sum", oldest_expect.group_sum, out_if.group_sum);
          compare_field("total_charge", oldest_expect.total_charge, out_if.total_charge);
          compare_field("tail_charge", oldest_expect.tail_charge, out_if.tail_charge);
          compare_field("peak_height", oldest_expect.peak_height, out_if.peak_height);
          compare_field("above_threshold", oldest_expect.above_threshold,
                        out_if.above_threshold);
          compare_field("waveform_end", oldest_expect.waveform_end, out_if.waveform_end);
          results_checked++;
          if (oldest_expect.waveform_end) ends_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = idle_enable ? draw_gap() : 0;
      end
    end
  end

  // Stimulus sequence
  initial begin
    int unsigned base;
    int unsigned span;
    int unsigned waves;
    int unsigned ts;
    int unsigned we;
    int unsigned tl;
    int unsigned th;

    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = REG_BASELINE;
    cfg_data          = '0;
    in_if.valid       = 1'b0;
    in_if.raw_sample  = '0;
    in_if.last_sample = 1'b0;
    out_if.ready      = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: forced-to-one, zero and partial last group; single-sample waveform
    idle_enable = 1'b1;
    phase_count++;
    queue_sample(0, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(RST_BASELINE, 1'b0);
    queue_sample(100, 1'b0);
    queue_sample(RST_BASELINE - 1, 1'b0);
    queue_sample(0, 1'b1);
    queue_sample(SAMPLE_MAX, 1'b1);
    wait_drained();

    // Full-scale samples, narrow windows, peak equal to threshold
    apply_settings(SAMPLE_MAX, 0, 2, 1, SAMPLE_MAX);
    for (int k = 0; k < 12; k++) queue_sample(0, k == 11);
    wait_drained();

    // Empty windows with starts at or beyond the end, peak just over threshold
    apply_settings(SAMPLE_MAX, 3, 2, BIN_LIMIT, SAMPLE_MAX - 1);
    for (int k = 0; k < 4; k++) queue_sample(0, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b1);
    wait_drained();

    // Random phases of short waveforms with random settings
    while (samples_queued < RANDOM_ITEMS + 24) begin
      case ($urandom_range(0, 3))
        0:       base = 0;
        1:       base = SAMPLE_MAX;
        default: base = $urandom_range(0, SAMPLE_MAX);
      endcase
      span = $urandom_range(1, 40);
      if ($urandom_range(0, 5) == 0) begin
        ts = $urandom_range(0, 1) ? BIN_LIMIT : 0;
        we = $urandom_range(0, 1) ? BIN_LIMIT : 0;
        tl = $urandom_range(0, 1) ? BIN_LIMIT : 0;
      end else begin
        ts = $urandom_range(0, span + 2);
        we = $urandom_range(0, span + 2);
        tl = $urandom_range(0, span + 2);
      end
      case ($urandom_range(0, 4))
        0:       th = 0;
        1:       th = SAMPLE_MAX;
        default: th = $urandom_range(0, base);
      endcase
      apply_settings(base, ts, we, tl, th);
      idle_enable = ($urandom_range(0, 4) != 0);
      waves = $urandom_range(1, 4);
      for (int w = 0; w < waves; w++)
        queue_waveform($urandom_range(1, GROUP_SIZE * span + 4), SAMPLE_BITS'(base));
      wait_drained();
    end

    // One over-length waveform: full total window, tail window from the middle bin, then ignored samples
    idle_enable = 1'b1;
    apply_settings(SAMPLE_MAX, 0, BIN_LIMIT, BIN_LIMIT / 2, $urandom_range(0, SAMPLE_MAX));
    queue_waveform(LONG_WAVE, SAMPLE_MAX);
    wait_drained();

    $display("Run covered %0d samples in %0d waveforms over %0d setting phases",
             samples_sent, waveforms_queued, phase_count);
    $display("Checked %0d results, %0d of them closing a waveform, %0d errors",
             results_checked, ends_checked, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
